>>> sv/ppl_pkg.sv
// ----------------------------------------------------------------------------
// ppl_pkg
// Shared widths, vector types and register codes of the point light shader.
// ----------------------------------------------------------------------------
package ppl_pkg;

   localparam int WIDE_W = 32;
   localparam int UNIT_W = 16;
   localparam int NRM_W = 23;
   localparam int NL_W = 24;
   localparam int PWR_W = 15;
   localparam int LEN2_W = 62;
   localparam int LEN_W = 31;
   localparam int REM_W = 45;
   localparam int QUO_W = 15;

   localparam int ISQRT_STEPS = 31;
   localparam int DIV_STEPS = 15;
   localparam int UNIT_LAT = ISQRT_STEPS + DIV_STEPS + 4;
   localparam int SHADE_LAT = 6;

   localparam logic [PWR_W-1:0] ONE_Q14 = 15'd16384;

   typedef enum logic [2:0] {
      CSR_LIGHT_POS_X,
      CSR_LIGHT_POS_Y,
      CSR_LIGHT_POS_Z,
      CSR_LIGHT_RED,
      CSR_LIGHT_GREEN,
      CSR_LIGHT_BLUE,
      CSR_SHININESS,
      CSR_LIGHT_ENABLE
   } csr_index_type;

   typedef logic [2:0][WIDE_W-1:0] wide_vec_type;
   typedef logic [2:0][UNIT_W-1:0] unit_vec_type;
   typedef logic [2:0][NRM_W-1:0] nrm_vec_type;
   typedef logic [2:0][7:0] rgb_type;
   typedef logic [2:0][15:0] chan16_type;

   typedef struct packed {
      rgb_type dif;
      rgb_type spec;
      rgb_type emi;
   } color_set_type;

endpackage

>>> sv/ppl_if.sv
// ----------------------------------------------------------------------------
// ppl_if
// Request and response channels of the point light shader.
// ----------------------------------------------------------------------------
interface ppl_req_if;
   logic        valid;
   logic        ready;
   logic [47:0] hit_pos;
   logic [47:0] ray_origin;
   logic [47:0] surface_normal;
   logic [23:0] diffuse_rgb;
   logic [23:0] specular_rgb;
   logic [23:0] emissive_rgb;

   modport source (output valid, hit_pos, ray_origin, surface_normal, diffuse_rgb,
                   specular_rgb, emissive_rgb, input ready);
   modport sink (input valid, hit_pos, ray_origin, surface_normal, diffuse_rgb,
                 specular_rgb, emissive_rgb, output ready);
endinterface

interface ppl_rsp_if;
   logic        valid;
   logic        ready;
   logic        scattered;
   logic [15:0] out_red;
   logic [15:0] out_green;
   logic [15:0] out_blue;

   modport source (output valid, scattered, out_red, out_green, out_blue, input ready);
   modport sink (input valid, scattered, out_red, out_green, out_blue, output ready);
endinterface

>>> sv/ppl_delay.sv
// ----------------------------------------------------------------------------
// ppl_delay
// Shift line that keeps side data in step with a pipelined unit.
// ----------------------------------------------------------------------------
module ppl_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [WIDTH-1:0] in_data,
   output logic [WIDTH-1:0] out_data
);
   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (adv) begin
         tap_ff[0] <= in_data;
         for (int k = 1; k < DEPTH; k++) begin
            tap_ff[k] <= tap_ff[k-1];
         end
      end
   end

   assign out_data = tap_ff[DEPTH-1];
endmodule

>>> sv/ppl_unit.sv
// ----------------------------------------------------------------------------
// ppl_unit
// Pipelined vector normalizer: squares, length by a bit-per-stage square
// root, then a bit-per-stage divide of each component by the length.
// ----------------------------------------------------------------------------
module ppl_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  ppl_pkg::wide_vec_type in_vec,
   output logic                  out_valid,
   output ppl_pkg::unit_vec_type out_vec
);
   import ppl_pkg::*;

   logic signed [63:0]        sq_in [3];
   logic                      a_valid_ff;
   wide_vec_type              a_c_ff;
   logic [2:0][LEN2_W-2:0]    a_sq_ff;

   logic [LEN2_W-1:0]         sq_x_ff [ISQRT_STEPS+1];
   logic [LEN2_W:0]           sq_r_ff [ISQRT_STEPS+1];
   wide_vec_type              sq_c_ff [ISQRT_STEPS+1];
   logic                      sq_v_ff [ISQRT_STEPS+1];

   logic [2:0][REM_W-1:0]     dv_rem_ff [DIV_STEPS+1];
   logic [2:0][QUO_W-1:0]     dv_q_ff [DIV_STEPS+1];
   logic [2:0]                dv_neg_ff [DIV_STEPS+1];
   logic [LEN_W-1:0]          dv_len_ff [DIV_STEPS+1];
   logic                      dv_v_ff [DIV_STEPS+1];

   logic                      out_valid_ff;
   unit_vec_type              out_vec_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = 64'($signed(in_vec[i]) * $signed(in_vec[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_c_ff <= in_vec;
         for (int i = 0; i < 3; i++) begin
            a_sq_ff[i] <= sq_in[i][LEN2_W-2:0];
         end
         sq_x_ff[0] <= LEN2_W'(a_sq_ff[0]) + LEN2_W'(a_sq_ff[1]) + LEN2_W'(a_sq_ff[2]);
         sq_r_ff[0] <= '0;
         sq_c_ff[0] <= a_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
         sq_v_ff[0] <= a_valid_ff;
      end
   end

   for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_sqrt
      localparam logic [LEN2_W:0] BIT = (LEN2_W+1)'(1) << (2 * (ISQRT_STEPS - 1 - k));
      logic [LEN2_W:0] trial;
      assign trial = sq_r_ff[k] + BIT;

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_c_ff[k+1] <= sq_c_ff[k];
            if ({1'b0, sq_x_ff[k]} >= trial) begin
               sq_x_ff[k+1] <= sq_x_ff[k] - trial[LEN2_W-1:0];
               sq_r_ff[k+1] <= (sq_r_ff[k] >> 1) + BIT;
            end else begin
               sq_x_ff[k+1] <= sq_x_ff[k];
               sq_r_ff[k+1] <= sq_r_ff[k] >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_len_ff[0] <= sq_r_ff[ISQRT_STEPS][LEN_W-1:0];
         dv_q_ff[0] <= '0;
         for (int i = 0; i < 3; i++) begin
            logic signed [WIDE_W-1:0] c;
            logic signed [WIDE_W-1:0] mag;
            c = $signed(sq_c_ff[ISQRT_STEPS][i]);
            mag = (c < 0) ? -c : c;
            dv_neg_ff[0][i] <= (c < 0);
            dv_rem_ff[0][i] <= {mag[LEN_W-1:0], 14'd0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= sq_v_ff[ISQRT_STEPS];
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int QB = QUO_W - 1 - j;
      logic [REM_W:0] shifted;
      assign shifted = (REM_W+1)'(dv_len_ff[j]) << QB;

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_len_ff[j+1] <= dv_len_ff[j];
            dv_neg_ff[j+1] <= dv_neg_ff[j];
            for (int i = 0; i < 3; i++) begin
               if ({1'b0, dv_rem_ff[j][i]} >= shifted) begin
                  dv_rem_ff[j+1][i] <= dv_rem_ff[j][i] - shifted[REM_W-1:0];
                  dv_q_ff[j+1][i] <= dv_q_ff[j][i] | (QUO_W'(1) << QB);
               end else begin
                  dv_rem_ff[j+1][i] <= dv_rem_ff[j][i];
                  dv_q_ff[j+1][i] <= dv_q_ff[j][i];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[j+1] <= dv_v_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            if (dv_len_ff[DIV_STEPS] == '0) begin
               out_vec_ff[i] <= '0;
            end else if (dv_neg_ff[DIV_STEPS][i]) begin
               out_vec_ff[i] <= -UNIT_W'(dv_q_ff[DIV_STEPS][i]);
            end else begin
               out_vec_ff[i] <= UNIT_W'(dv_q_ff[DIV_STEPS][i]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= dv_v_ff[DIV_STEPS];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_vec = out_vec_ff;
endmodule

>>> sv/ppl_pow.sv
// ----------------------------------------------------------------------------
// ppl_pow
// Specular power by square-and-multiply, one exponent bit per stage.
// ----------------------------------------------------------------------------
module ppl_pow #(
   parameter int MAX_SHININESS_BITS = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  logic [ppl_pkg::PWR_W-1:0] in_base,
   input  logic [7:0]                shininess,
   output logic                      out_valid,
   output logic [ppl_pkg::PWR_W-1:0] out_pow
);
   import ppl_pkg::*;

   localparam int EW = MAX_SHININESS_BITS + 1;
   localparam int XW = (EW > 8) ? EW : 8;
   localparam logic [XW-1:0] CAP = XW'(1) << MAX_SHININESS_BITS;

   function automatic logic [PWR_W-1:0] qmul(input logic [PWR_W-1:0] a,
                                            input logic [PWR_W-1:0] b);
      logic [2*PWR_W-1:0] prod;
      prod = (2*PWR_W)'(a) * (2*PWR_W)'(b) + (2*PWR_W)'(8192);
      return prod[PWR_W+13:14];
   endfunction

   logic [XW-1:0]     exp_ext;
   logic [EW-1:0]     expo;
   logic [PWR_W-1:0]  acc_ff [EW+1];
   logic [PWR_W-1:0]  base_ff [EW+1];
   logic              v_ff [EW+1];

   assign exp_ext = XW'(shininess);
   assign expo = (exp_ext > CAP) ? CAP[EW-1:0] : exp_ext[EW-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         acc_ff[0] <= ONE_Q14;
         base_ff[0] <= in_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
   end

   for (genvar k = 0; k < EW; k++) begin : g_bit
      always_ff @(posedge clock) begin
         if (adv) begin
            acc_ff[k+1] <= expo[k] ? qmul(acc_ff[k], base_ff[k]) : acc_ff[k];
            base_ff[k+1] <= qmul(base_ff[k], base_ff[k]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            v_ff[k+1] <= v_ff[k];
         end
      end
   end

   assign out_valid = v_ff[EW];
   assign out_pow = acc_ff[EW];

   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_pow <= ONE_Q14))
      else $error("specular power above one");
endmodule

>>> sv/ppl_shade.sv
// ----------------------------------------------------------------------------
// ppl_shade
// Per-channel color combine, scale by the light and divide by 255 * 2^14
// with saturation. The last stage is the response register.
// ----------------------------------------------------------------------------
module ppl_shade (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  logic [ppl_pkg::NL_W-1:0]  in_nl,
   input  logic [ppl_pkg::PWR_W-1:0] in_pow,
   input  ppl_pkg::color_set_type    in_colors,
   input  ppl_pkg::chan16_type       light_rgb,
   input  logic                      light_enable,
   output logic                      out_valid,
   output logic                      out_scattered,
   output ppl_pkg::chan16_type       out_rgb
);
   import ppl_pkg::*;

   localparam logic [35:0] SAT_LIMIT = 36'd16711680;

   logic [SHADE_LAT-1:0] v_ff;
   logic [2:0][31:0]     dn_ff;
   logic [2:0][22:0]     sp_ff;
   rgb_type              e1_ff, e2_ff;
   logic [2:0][48:0]     a_ff;
   logic [2:0][23:0]     x3_ff, x4_ff;
   logic [2:0]           sat3_ff, sat4_ff, sat5_ff;
   logic [2:0][32:0]     m_ff;
   logic [2:0][15:0]     q0_ff;
   logic [2:0][9:0]      r_ff;
   logic                 scat_ff;
   chan16_type           rgb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[SHADE_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_ff <= in_colors.emi;
         e2_ff <= e1_ff;
         for (int i = 0; i < 3; i++) begin
            logic [32:0] sum;
            logic [49:0] acc;
            logic [35:0] xs;
            logic [16:0] q;
            dn_ff[i] <= 32'(in_colors.dif[i]) * 32'(in_nl);
            sp_ff[i] <= 23'(in_colors.spec[i]) * 23'(in_pow);

            sum = 33'(dn_ff[i]) + 33'(sp_ff[i]);
            a_ff[i] <= 49'(sum) * 49'(light_rgb[i]);

            acc = 50'(a_ff[i]) + {20'd0, e2_ff[i], 22'd0};
            xs = acc[49:14];
            x3_ff[i] <= xs[23:0];
            sat3_ff[i] <= (xs >= SAT_LIMIT);

            m_ff[i] <= 33'(x3_ff[i]) * 33'd257;
            x4_ff[i] <= x3_ff[i];
            sat4_ff[i] <= sat3_ff[i];

            q0_ff[i] <= m_ff[i][31:16];
            r_ff[i] <= 10'(x4_ff[i] - ({8'd0, m_ff[i][31:16]} << 8)
                           + {8'd0, m_ff[i][31:16]});
            sat5_ff[i] <= sat4_ff[i];

            if (r_ff[i] >= 10'd510) begin
               q = 17'(q0_ff[i]) + 17'd2;
            end else if (r_ff[i] >= 10'd255) begin
               q = 17'(q0_ff[i]) + 17'd1;
            end else begin
               q = 17'(q0_ff[i]);
            end
            if (!light_enable) begin
               rgb_ff[i] <= '0;
            end else if (sat5_ff[i] || q[16]) begin
               rgb_ff[i] <= 16'hFFFF;
            end else begin
               rgb_ff[i] <= q[15:0];
            end
         end
         scat_ff <= light_enable;
      end
   end

   assign out_valid = v_ff[SHADE_LAT-1];
   assign out_scattered = scat_ff;
   assign out_rgb = rgb_ff;
endmodule

>>> sv/phong_point_light_shader.sv
// ----------------------------------------------------------------------------
// phong_point_light_shader
// The path from request to response runs through three normalizers of 50
// stages each, two of them in series.
// Throughput: one request per cycle; a stalled response holds every stage.
// Reset clears all valid bits and loads the light registers with their
// defaults: position zero, color 1.0, shininess 32, light disabled.
// ----------------------------------------------------------------------------
module phong_point_light_shader #(
   parameter int COORD_BITS = 16,
   parameter int MAX_SHININESS_BITS = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   ppl_req_if.sink                req_bus,
   ppl_rsp_if.source              rsp_bus,
   input  logic                   csr_wr_en,
   input  ppl_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_wdata
);
   import ppl_pkg::*;

   localparam int PADW = (3 * COORD_BITS > 48) ? 3 * COORD_BITS : 48;
   localparam int POW_LAT = MAX_SHININESS_BITS + 2;
   localparam logic signed [33:0] VEC_MAX = 34'sd1073741824;
   localparam logic signed [33:0] VEC_MIN = -34'sd1073741824;
   localparam logic signed [33:0] NRM_MAX = 34'sd65535;
   localparam logic signed [33:0] NRM_MIN = -34'sd65536;

   function automatic logic [WIDE_W-1:0] clamp_vec(input logic signed [33:0] d);
      logic signed [33:0] c;
      c = (d > VEC_MAX) ? VEC_MAX : ((d < VEC_MIN) ? VEC_MIN : d);
      return c[WIDE_W-1:0];
   endfunction

   // Light registers.
   logic [2:0][15:0] lpos_ff;
   chan16_type       lcol_ff;
   logic [7:0]       shin_ff;
   logic             enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lpos_ff <= '0;
         lcol_ff <= {3{16'd256}};
         shin_ff <= 8'd32;
         enable_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LIGHT_POS_X: lpos_ff[0] <= csr_wdata;
            CSR_LIGHT_POS_Y: lpos_ff[1] <= csr_wdata;
            CSR_LIGHT_POS_Z: lpos_ff[2] <= csr_wdata;
            CSR_LIGHT_RED: lcol_ff[0] <= csr_wdata;
            CSR_LIGHT_GREEN: lcol_ff[1] <= csr_wdata;
            CSR_LIGHT_BLUE: lcol_ff[2] <= csr_wdata;
            CSR_SHININESS: shin_ff <= csr_wdata[7:0];
            CSR_LIGHT_ENABLE: enable_ff <= csr_wdata[0];
            default: enable_ff <= enable_ff;
         endcase
      end
   end

   logic adv;
   logic out_valid;
   assign adv = !out_valid || rsp_bus.ready;
   assign req_bus.ready = adv;

   // Request decode.
   logic [PADW-1:0] hp_ext, ro_ext, sn_ext;
   wide_vec_type    dl_in, dv_in;
   nrm_vec_type     n_in;

   assign hp_ext = PADW'(req_bus.hit_pos);
   assign ro_ext = PADW'(req_bus.ray_origin);
   assign sn_ext = PADW'(req_bus.surface_normal);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [33:0] h, o, nn, lp;
         h = 34'($signed(hp_ext[i*COORD_BITS +: COORD_BITS]));
         o = 34'($signed(ro_ext[i*COORD_BITS +: COORD_BITS]));
         nn = 34'($signed(sn_ext[i*COORD_BITS +: COORD_BITS]));
         lp = 34'($signed(lpos_ff[i]));
         dl_in[i] = clamp_vec(lp - h);
         dv_in[i] = clamp_vec(o - h);
         nn = (nn > NRM_MAX) ? NRM_MAX : ((nn < NRM_MIN) ? NRM_MIN : nn);
         n_in[i] = {nn[16:0], 6'd0};
      end
   end

   logic          p0_valid_ff;
   wide_vec_type  p0_dl_ff, p0_dv_ff;
   nrm_vec_type   p0_n_ff;
   color_set_type p0_col_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_dl_ff <= dl_in;
         p0_dv_ff <= dv_in;
         p0_n_ff <= n_in;
         p0_col_ff.dif <= req_bus.diffuse_rgb;
         p0_col_ff.spec <= req_bus.specular_rgb;
         p0_col_ff.emi <= req_bus.emissive_rgb;
      end
   end

   // Light and view directions.
   logic          lu_valid, vu_valid;
   unit_vec_type  l_vec, v_vec;
   nrm_vec_type   a_n;
   color_set_type a_col;

   ppl_unit u_unit_l (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(p0_valid_ff),
      .in_vec(p0_dl_ff), .out_valid(lu_valid), .out_vec(l_vec)
   );

   ppl_unit u_unit_v (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(p0_valid_ff),
      .in_vec(p0_dv_ff), .out_valid(vu_valid), .out_vec(v_vec)
   );

   ppl_delay #(.WIDTH($bits(nrm_vec_type) + $bits(color_set_type)), .DEPTH(UNIT_LAT))
   u_delay_a (
      .clock(clock), .adv(adv), .in_data({p0_n_ff, p0_col_ff}), .out_data({a_n, a_col})
   );

   // Diffuse term and reflection vector.
   logic               n1_valid_ff, n2_valid_ff, d1_valid_ff, d2_valid_ff;
   logic [2:0][37:0]   n1_prod_ff;
   nrm_vec_type        n1_n_ff, n2_n_ff;
   unit_vec_type       n1_l_ff, n2_l_ff, d1_l_ff;
   unit_vec_type       n1_v_ff, n2_v_ff, d1_v_ff, d2_v_ff;
   color_set_type      n1_col_ff, n2_col_ff, d1_col_ff, d2_col_ff;
   logic [NL_W-1:0]    n2_nl_ff, d1_nl_ff, d2_nl_ff;
   logic [2:0][48:0]   d1_prod_ff;
   wide_vec_type       d2_dr_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         logic signed [38:0] dot;
         for (int i = 0; i < 3; i++) begin
            n1_prod_ff[i] <= 38'($signed(a_n[i]) * $signed(l_vec[i]));
         end
         n1_n_ff <= a_n;
         n1_l_ff <= l_vec;
         n1_v_ff <= v_vec;
         n1_col_ff <= a_col;

         dot = 39'($signed(n1_prod_ff[0])) + 39'($signed(n1_prod_ff[1]))
             + 39'($signed(n1_prod_ff[2]));
         n2_nl_ff <= (dot <= 0) ? '0 : dot[37:14];
         n2_n_ff <= n1_n_ff;
         n2_l_ff <= n1_l_ff;
         n2_v_ff <= n1_v_ff;
         n2_col_ff <= n1_col_ff;

         for (int i = 0; i < 3; i++) begin
            d1_prod_ff[i] <= 49'($signed({1'b0, n2_nl_ff, 1'b0}) * $signed(n2_n_ff[i]));
         end
         d1_l_ff <= n2_l_ff;
         d1_v_ff <= n2_v_ff;
         d1_nl_ff <= n2_nl_ff;
         d1_col_ff <= n2_col_ff;

         for (int i = 0; i < 3; i++) begin
            logic signed [48:0] pr;
            logic signed [48:0] tq;
            pr = $signed(d1_prod_ff[i]);
            tq = (pr < 0) ? ((pr + 49'sd16383) >>> 14) : (pr >>> 14);
            d2_dr_ff[i] <= clamp_vec(34'(tq) - 34'($signed(d1_l_ff[i])));
         end
         d2_v_ff <= d1_v_ff;
         d2_nl_ff <= d1_nl_ff;
         d2_col_ff <= d1_col_ff;
      end
   end

   // Reflection direction.
   logic          ru_valid;
   unit_vec_type  r_vec, b_v;
   logic [NL_W-1:0] b_nl;
   color_set_type b_col;

   ppl_unit u_unit_r (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(d2_valid_ff),
      .in_vec(d2_dr_ff), .out_valid(ru_valid), .out_vec(r_vec)
   );

   ppl_delay #(.WIDTH($bits(unit_vec_type) + NL_W + $bits(color_set_type)),
               .DEPTH(UNIT_LAT))
   u_delay_b (
      .clock(clock), .adv(adv), .in_data({d2_v_ff, d2_nl_ff, d2_col_ff}),
      .out_data({b_v, b_nl, b_col})
   );

   // Specular base.
   logic              vr1_valid_ff, vr2_valid_ff;
   logic [2:0][31:0]  vr1_prod_ff;
   logic [NL_W-1:0]   vr1_nl_ff, vr2_nl_ff;
   color_set_type     vr1_col_ff, vr2_col_ff;
   logic [PWR_W-1:0]  vr2_base_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         logic signed [32:0] s;
         logic [32:0]        sh;
         for (int i = 0; i < 3; i++) begin
            vr1_prod_ff[i] <= 32'($signed(b_v[i]) * $signed(r_vec[i]));
         end
         vr1_nl_ff <= b_nl;
         vr1_col_ff <= b_col;

         s = 33'($signed(vr1_prod_ff[0])) + 33'($signed(vr1_prod_ff[1]))
           + 33'($signed(vr1_prod_ff[2]));
         sh = 33'(s) >> 14;
         if (s <= 0) begin
            vr2_base_ff <= '0;
         end else if (sh > 33'(ONE_Q14)) begin
            vr2_base_ff <= ONE_Q14;
         end else begin
            vr2_base_ff <= sh[PWR_W-1:0];
         end
         vr2_nl_ff <= vr1_nl_ff;
         vr2_col_ff <= vr1_col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         n1_valid_ff <= 1'b0;
         n2_valid_ff <= 1'b0;
         d1_valid_ff <= 1'b0;
         d2_valid_ff <= 1'b0;
         vr1_valid_ff <= 1'b0;
         vr2_valid_ff <= 1'b0;
      end else if (adv) begin
         p0_valid_ff <= req_bus.valid;
         n1_valid_ff <= lu_valid;
         n2_valid_ff <= n1_valid_ff;
         d1_valid_ff <= n2_valid_ff;
         d2_valid_ff <= d1_valid_ff;
         vr1_valid_ff <= ru_valid;
         vr2_valid_ff <= vr1_valid_ff;
      end
   end

   // Specular power and final color.
   logic             pw_valid;
   logic [PWR_W-1:0] pw_val;
   logic [NL_W-1:0]  c_nl;
   color_set_type    c_col;

   ppl_pow #(.MAX_SHININESS_BITS(MAX_SHININESS_BITS)) u_pow (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(vr2_valid_ff),
      .in_base(vr2_base_ff), .shininess(shin_ff), .out_valid(pw_valid), .out_pow(pw_val)
   );

   ppl_delay #(.WIDTH(NL_W + $bits(color_set_type)), .DEPTH(POW_LAT)) u_delay_c (
      .clock(clock), .adv(adv), .in_data({vr2_nl_ff, vr2_col_ff}), .out_data({c_nl, c_col})
   );

   chan16_type out_rgb;

   ppl_shade u_shade (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(pw_valid), .in_nl(c_nl),
      .in_pow(pw_val), .in_colors(c_col), .light_rgb(lcol_ff), .light_enable(enable_ff),
      .out_valid(out_valid), .out_scattered(rsp_bus.scattered), .out_rgb(out_rgb)
   );

   assign rsp_bus.valid = out_valid;
   assign rsp_bus.out_red = out_rgb[0];
   assign rsp_bus.out_green = out_rgb[1];
   assign rsp_bus.out_blue = out_rgb[2];

   assert property (@(posedge clock) disable iff (reset) lu_valid == vu_valid)
      else $error("light and view normalizers out of step");

   assert property (@(posedge clock) $past(reset) |-> !rsp_bus.valid)
      else $error("response valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.scattered) |->
         (rsp_bus.out_red == '0 && rsp_bus.out_green == '0 && rsp_bus.out_blue == '0))
      else $error("unlit response carries color");

   assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(vr2_valid_ff) && $stable(d2_valid_ff)))
      else $error("pipeline moved during a stall");
endmodule
